// File: hdl/fcc_pkg.sv
// Package for the folded collation compare block.
// Holds the verdict and basis codes, the per-position step struct and the
// case-fold and weight functions. No dependencies.
package fcc_pkg;

   localparam int unsigned CharWidth   = 16;
   localparam int unsigned WeightWidth = CharWidth + 1;

   localparam logic [CharWidth-1:0] LatinUpperFirst    = 16'h0041;
   localparam logic [CharWidth-1:0] LatinUpperLast     = 16'h005A;
   localparam logic [CharWidth-1:0] CyrillicUpperFirst = 16'h0410;
   localparam logic [CharWidth-1:0] CyrillicUpperLast  = 16'h042F;
   localparam logic [CharWidth-1:0] CaseOffset         = 16'h0020;
   localparam logic [CharWidth-1:0] CyrillicUpperIo    = 16'h0401;
   localparam logic [CharWidth-1:0] CyrillicLowerIo    = 16'h0451;
   localparam logic [CharWidth-1:0] CyrillicLowerIe    = 16'h0435;

   typedef enum logic [1:0] {
      VERDICT_NONE = 2'd0,
      VERDICT_LESS = 2'd1,
      VERDICT_MORE = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      BASIS_WEIGHT = 2'd0,
      BASIS_LENGTH = 2'd1,
      BASIS_RAW    = 2'd2,
      BASIS_EQUAL  = 2'd3
   } basis_type;

   localparam logic signed [1:0] OrderBefore = -2'sd1;
   localparam logic signed [1:0] OrderEqual  = 2'sd0;
   localparam logic signed [1:0] OrderAfter  = 2'sd1;

   // One position as it leaves the compare logic.
   typedef struct packed {
      logic        has_a;
      logic        has_b;
      logic        last;
      verdict_type key_cmp;
      verdict_type raw_cmp;
   } step_type;

   typedef struct packed {
      logic signed [1:0] order;
      basis_type         basis;
   } result_type;

   function automatic logic [CharWidth-1:0] fold_unit(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] folded;
      folded = c;
      if ((c >= LatinUpperFirst && c <= LatinUpperLast) ||
          (c >= CyrillicUpperFirst && c <= CyrillicUpperLast)) begin
         folded = c + CaseOffset;
      end else if (c == CyrillicUpperIo) begin
         folded = CyrillicLowerIo;
      end
      return folded;
   endfunction

   // Lower-case io sorts directly after lower-case ie.
   function automatic logic [WeightWidth-1:0] unit_weight(input logic [CharWidth-1:0] f);
      logic [WeightWidth-1:0] w;
      if (f == CyrillicLowerIo) begin
         w = {CyrillicLowerIe, 1'b1};
      end else begin
         w = {f, 1'b0};
      end
      return w;
   endfunction

endpackage

// File: hdl/folded_collation_compare_top.sv
// Top level of the folded collation compare block: input register, compare
// logic, verdict tracking and output register. Depends on fcc_pkg,
// fcc_unit_cmp and fcc_verdict_track.
//
// Usage: two UTF-16 strings A and B are streamed one position per req
// transfer. req_tdata carries the code units of A and B, req_tuser the two
// presence flags, and req_tlast marks the final position of the pair.
// Positions without req_tlast produce no result; the transfer with
// req_tlast produces exactly one rsp transfer holding order and basis,
// and the verdict state then clears for the next pair.
// The result of a last position is held in the input register and then
// in the output register, which offers it on rsp. Throughput: one position
// per cycle, sustained while no last position waits for the output slot, set by
// the single registered pass through the fold, weight and compare logic.
// While a result waits in the output register, positions that are not
// last keep flowing in; only a second last position waits for the
// receiver, and then req_tready drops until rsp_tready frees the slot.
// Reset is synchronous and active high; it empties both registers and
// clears the verdict state, after which both strings count as empty.
module folded_collation_compare_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] char_a, [31:16] char_b
   input  logic [1:0]  req_tuser,   // [0] has_a, [1] has_b
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] order (signed), [3:2] basis, [7:4] zero
);

   // Input register stage.
   logic                          s1_valid_ff, s1_valid_in;
   logic [fcc_pkg::CharWidth-1:0] s1_char_a_ff;
   logic [fcc_pkg::CharWidth-1:0] s1_char_b_ff;
   logic                          s1_has_a_ff;
   logic                          s1_has_b_ff;
   logic                          s1_last_ff;
   logic                          s1_advance;

   // Output register stage.
   logic                          out_valid_ff, out_valid_in;
   fcc_pkg::result_type           out_result_ff;

   fcc_pkg::verdict_type          key_cmp;
   fcc_pkg::verdict_type          raw_cmp;
   fcc_pkg::step_type             step;
   fcc_pkg::result_type           result;
   logic                          out_load;

   // A position that is not last never needs the output slot, so it moves
   // on regardless of the receiver.
   assign s1_advance  = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;
   assign out_load    = s1_advance && s1_last_ff;

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_a_ff <= req_tdata[15:0];
         s1_char_b_ff <= req_tdata[31:16];
         s1_has_a_ff  <= req_tuser[0];
         s1_has_b_ff  <= req_tuser[1];
         s1_last_ff   <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_result_ff <= result;
      end
   end

   fcc_unit_cmp u_unit_cmp (
      .char_a  (s1_char_a_ff),
      .char_b  (s1_char_b_ff),
      .key_cmp (key_cmp),
      .raw_cmp (raw_cmp)
   );

   always_comb begin
      step.has_a   = s1_has_a_ff;
      step.has_b   = s1_has_b_ff;
      step.last    = s1_last_ff;
      step.key_cmp = key_cmp;
      step.raw_cmp = raw_cmp;
   end

   fcc_verdict_track u_verdict (
      .clock      (clock),
      .reset      (reset),
      .step_valid (s1_advance),
      .step       (step),
      .result     (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.basis, out_result_ff.order};

endmodule

// File: hdl/fcc_unit_cmp.sv
// Per-position compare: folds and weights both code units and compares
// the weights and the raw units. Depends on fcc_pkg.
module fcc_unit_cmp (
   input  logic [fcc_pkg::CharWidth-1:0] char_a,
   input  logic [fcc_pkg::CharWidth-1:0] char_b,
   output fcc_pkg::verdict_type          key_cmp,
   output fcc_pkg::verdict_type          raw_cmp
);

   logic [fcc_pkg::WeightWidth-1:0] weight_a;
   logic [fcc_pkg::WeightWidth-1:0] weight_b;

   assign weight_a = fcc_pkg::unit_weight(fcc_pkg::fold_unit(char_a));
   assign weight_b = fcc_pkg::unit_weight(fcc_pkg::fold_unit(char_b));

   always_comb begin
      if (weight_a == weight_b) begin
         key_cmp = fcc_pkg::VERDICT_NONE;
      end else if (weight_a < weight_b) begin
         key_cmp = fcc_pkg::VERDICT_LESS;
      end else begin
         key_cmp = fcc_pkg::VERDICT_MORE;
      end
   end

   always_comb begin
      if (char_a == char_b) begin
         raw_cmp = fcc_pkg::VERDICT_NONE;
      end else if (char_a < char_b) begin
         raw_cmp = fcc_pkg::VERDICT_LESS;
      end else begin
         raw_cmp = fcc_pkg::VERDICT_MORE;
      end
   end

endmodule

// File: hdl/fcc_verdict_track.sv
// Running verdict state for one string pair and the final decision on the
// last position. Depends on fcc_pkg.
module fcc_verdict_track (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  fcc_pkg::step_type    step,
   output fcc_pkg::result_type  result
);

   fcc_pkg::verdict_type key_ff, key_in;
   fcc_pkg::verdict_type len_ff, len_in;
   fcc_pkg::verdict_type raw_ff, raw_in;
   logic                 ended_a_ff, ended_a_in;
   logic                 ended_b_ff, ended_b_in;

   logic                 pres_a;
   logic                 pres_b;
   fcc_pkg::verdict_type key_new;
   fcc_pkg::verdict_type len_new;
   fcc_pkg::verdict_type raw_new;

   assign pres_a = step.has_a && !ended_a_ff;
   assign pres_b = step.has_b && !ended_b_ff;

   always_comb begin
      key_new = key_ff;
      len_new = len_ff;
      raw_new = raw_ff;
      if (pres_a && pres_b) begin
         if (key_ff == fcc_pkg::VERDICT_NONE) begin
            key_new = step.key_cmp;
         end
         if (raw_ff == fcc_pkg::VERDICT_NONE) begin
            raw_new = step.raw_cmp;
         end
      end else if (pres_a) begin
         if (len_ff == fcc_pkg::VERDICT_NONE) begin
            len_new = fcc_pkg::VERDICT_MORE;
         end
      end else if (pres_b) begin
         if (len_ff == fcc_pkg::VERDICT_NONE) begin
            len_new = fcc_pkg::VERDICT_LESS;
         end
      end
   end

   // A run ends on the last position, which leaves a clean slate.
   always_comb begin
      key_in     = key_ff;
      len_in     = len_ff;
      raw_in     = raw_ff;
      ended_a_in = ended_a_ff;
      ended_b_in = ended_b_ff;
      if (step_valid) begin
         if (step.last) begin
            key_in     = fcc_pkg::VERDICT_NONE;
            len_in     = fcc_pkg::VERDICT_NONE;
            raw_in     = fcc_pkg::VERDICT_NONE;
            ended_a_in = 1'b0;
            ended_b_in = 1'b0;
         end else begin
            key_in     = key_new;
            len_in     = len_new;
            raw_in     = raw_new;
            ended_a_in = ended_a_ff || !pres_a;
            ended_b_in = ended_b_ff || !pres_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= fcc_pkg::VERDICT_NONE;
         len_ff     <= fcc_pkg::VERDICT_NONE;
         raw_ff     <= fcc_pkg::VERDICT_NONE;
         ended_a_ff <= 1'b0;
         ended_b_ff <= 1'b0;
      end else begin
         key_ff     <= key_in;
         len_ff     <= len_in;
         raw_ff     <= raw_in;
         ended_a_ff <= ended_a_in;
         ended_b_ff <= ended_b_in;
      end
   end

   function automatic logic signed [1:0] to_order(input fcc_pkg::verdict_type v);
      logic signed [1:0] o;
      case (v)
         fcc_pkg::VERDICT_LESS: o = fcc_pkg::OrderBefore;
         fcc_pkg::VERDICT_MORE: o = fcc_pkg::OrderAfter;
         default:               o = fcc_pkg::OrderEqual;
      endcase
      return o;
   endfunction

   always_comb begin
      if (key_new != fcc_pkg::VERDICT_NONE) begin
         result.basis = fcc_pkg::BASIS_WEIGHT;
         result.order = to_order(key_new);
      end else if (len_new != fcc_pkg::VERDICT_NONE) begin
         result.basis = fcc_pkg::BASIS_LENGTH;
         result.order = to_order(len_new);
      end else if (raw_new != fcc_pkg::VERDICT_NONE) begin
         result.basis = fcc_pkg::BASIS_RAW;
         result.order = to_order(raw_new);
      end else begin
         result.basis = fcc_pkg::BASIS_EQUAL;
         result.order = fcc_pkg::OrderEqual;
      end
   end

endmodule

// File: hdl/fcc_checker.sv
// Port-level checker for folded_collation_compare_top, bound to the top
// level below. Depends on fcc_pkg.
module fcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic [1:0] rsp_order;
   logic [1:0] rsp_basis;

   assign rsp_order = rsp_tdata[1:0];
   assign rsp_basis = rsp_tdata[3:2];

   // A result offered and not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp result changed while stalled");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // Full equality always comes with a zero order.
   a_equal_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_basis == fcc_pkg::BASIS_EQUAL |-> rsp_order == 2'b00)
      else $error("equal basis with nonzero order");

   // Any deciding basis gives a strict order.
   a_decided_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_basis != fcc_pkg::BASIS_EQUAL
         |-> rsp_order == 2'b01 || rsp_order == 2'b11)
      else $error("decided basis without strict order");

   // The padding bits stay zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] == 4'b0000)
      else $error("rsp padding bits not zero");

endmodule

bind folded_collation_compare_top fcc_checker u_fcc_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for folded_collation_compare_top: directed rows, then random
// string pairs, checked against a behavioral collation predictor.
// Depends on fcc_pkg for the verdict, basis and result types and the fold constants.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any transfer before the run is declared hung. The slowest
   // correct stretch is a sender gap plus a receiver stall plus the pass through
   // the input and output registers, well under this.
   localparam int unsigned QuietLimit = 500;
   localparam int unsigned TargetItems = 1250;
   localparam int unsigned CalmFrom = 1100;
   localparam int unsigned MaxLen = 64;

   // Short names for the result codes used in the directed table.
   localparam logic signed [1:0] OrdBefore = fcc_pkg::OrderBefore;
   localparam logic signed [1:0] OrdEqual  = fcc_pkg::OrderEqual;
   localparam logic signed [1:0] OrdAfter  = fcc_pkg::OrderAfter;
   localparam fcc_pkg::basis_type ByWeight = fcc_pkg::BASIS_WEIGHT;
   localparam fcc_pkg::basis_type ByLength = fcc_pkg::BASIS_LENGTH;
   localparam fcc_pkg::basis_type ByRaw    = fcc_pkg::BASIS_RAW;
   localparam fcc_pkg::basis_type ByEqual  = fcc_pkg::BASIS_EQUAL;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] char_a, [31:16] char_b
   logic [1:0]  req_tuser = '0;   // [0] has_a, [1] has_b
   logic        req_tlast = 1'b0; // last position of the string pair
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;        // [1:0] order (signed), [3:2] basis, [7:4] zero

   folded_collation_compare_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Predictor state: the three verdict registers and the end-of-string flags.
   fcc_pkg::verdict_type key_rank;
   fcc_pkg::verdict_type length_rank;
   fcc_pkg::verdict_type raw_rank;
   bit                   ended_a;
   bit                   ended_b;

   fcc_pkg::result_type  pending_verdicts[$];
   int unsigned          error_count = 0;
   int unsigned          quiet_cycles = 0;
   bit                   calm = 1'b0;   // once set, neither side idles any more

   // One row of the directed table. When known is set, the expected verdict is
   // taken from the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic [15:0]       char_a;
      logic [15:0]       char_b;
      logic              has_a;
      logic              has_b;
      logic              last;
      logic              known;
      logic signed [1:0] order;
      fcc_pkg::basis_type basis;
   } plan_row_type;

   localparam int unsigned PlanRows = 24;

   plan_row_type plan [PlanRows] = '{
      // Both strings empty: equal on every basis.
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, OrdEqual,  ByEqual},
      // Upper and lower case fold to the same weight, the raw unit decides.
      '{16'h0041, 16'h0061, 1'b1, 1'b1, 1'b1, 1'b1, OrdBefore, ByRaw},
      // Extremes of the code unit range.
      '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1, OrdAfter,  ByWeight},
      '{16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, OrdBefore, ByWeight},
      // Only one string present: the longer one is greater.
      '{16'h1234, 16'hBEEF, 1'b1, 1'b0, 1'b1, 1'b1, OrdAfter,  ByLength},
      '{16'hDEAD, 16'h5678, 1'b0, 1'b1, 1'b1, 1'b1, OrdBefore, ByLength},
      // Capital io folds to small io, which sorts just after small ie.
      '{16'h0401, 16'h0435, 1'b1, 1'b1, 1'b1, 1'b1, OrdAfter,  ByWeight},
      '{16'h0451, 16'h0436, 1'b1, 1'b1, 1'b1, 1'b1, OrdBefore, ByWeight},
      // Cyrillic capital A against small a.
      '{16'h0410, 16'h0430, 1'b1, 1'b1, 1'b1, 1'b1, OrdBefore, ByRaw},
      // Edges of the folded ranges.
      '{16'h042F, 16'h040F, 1'b1, 1'b1, 1'b1, 1'b0, OrdEqual,  ByEqual},
      '{16'h0430, 16'h0410, 1'b1, 1'b1, 1'b1, 1'b0, OrdEqual,  ByEqual},
      '{16'h0040, 16'h0060, 1'b1, 1'b1, 1'b1, 1'b0, OrdEqual,  ByEqual},
      '{16'h005B, 16'h007B, 1'b1, 1'b1, 1'b1, 1'b0, OrdEqual,  ByEqual},
      // An early raw difference loses to a later weight difference.
      '{16'h0061, 16'h0041, 1'b1, 1'b1, 1'b0, 1'b0, OrdEqual,  ByEqual},
      '{16'h0062, 16'h0063, 1'b1, 1'b1, 1'b1, 1'b0, OrdEqual,  ByEqual},
      // Raw difference, an empty position, then A present again after its end.
      '{16'h0061, 16'h0041, 1'b1, 1'b1, 1'b0, 1'b0, OrdEqual,  ByEqual},
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, OrdEqual,  ByEqual},
      '{16'h0042, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, OrdEqual,  ByEqual},
      // A ends, then claims presence again; that later unit must be ignored.
      '{16'h0441, 16'h0421, 1'b1, 1'b1, 1'b0, 1'b0, OrdEqual,  ByEqual},
      '{16'hABCD, 16'h0441, 1'b0, 1'b1, 1'b0, 1'b0, OrdEqual,  ByEqual},
      '{16'h0441, 16'h0441, 1'b1, 1'b1, 1'b1, 1'b0, OrdEqual,  ByEqual},
      // Both io forms weigh the same; the raw units still differ.
      '{16'h0401, 16'h0451, 1'b1, 1'b1, 1'b0, 1'b0, OrdEqual,  ByEqual},
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, OrdEqual,  ByEqual},
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, OrdEqual,  ByEqual}
   };

   function automatic logic [15:0] case_fold(input logic [15:0] u);
      if ((u >= fcc_pkg::LatinUpperFirst && u <= fcc_pkg::LatinUpperLast) ||
          (u >= fcc_pkg::CyrillicUpperFirst && u <= fcc_pkg::CyrillicUpperLast)) begin
         return u + fcc_pkg::CaseOffset;
      end
      if (u == fcc_pkg::CyrillicUpperIo) begin
         return fcc_pkg::CyrillicLowerIo;
      end
      return u;
   endfunction

   // Weight is twice the folded unit; small io slots in one above small ie.
   function automatic logic [16:0] sort_weight(input logic [15:0] f);
      if (f == fcc_pkg::CyrillicLowerIo) begin
         return {fcc_pkg::CyrillicLowerIe, 1'b1};
      end
      return {f, 1'b0};
   endfunction

   function automatic fcc_pkg::verdict_type rank(input logic [16:0] x,
                                                 input logic [16:0] y);
      if (x == y) begin
         return fcc_pkg::VERDICT_NONE;
      end
      return (x < y) ? fcc_pkg::VERDICT_LESS : fcc_pkg::VERDICT_MORE;
   endfunction

   function automatic logic signed [1:0] order_of(input fcc_pkg::verdict_type v);
      return (v == fcc_pkg::VERDICT_LESS) ? fcc_pkg::OrderBefore : fcc_pkg::OrderAfter;
   endfunction

   // Advances the predictor by one position. On the last position it returns
   // the verdict and clears the state for the next pair.
   task automatic collate_position(input logic [15:0] ca, input logic [15:0] cb,
                                   input logic ha, input logic hb, input logic fin,
                                   output bit produced,
                                   output fcc_pkg::result_type verdict);
      logic pa;
      logic pb;
      pa = ha && !ended_a;
      pb = hb && !ended_b;
      if (!pa) begin
         ended_a = 1'b1;
      end
      if (!pb) begin
         ended_b = 1'b1;
      end
      if (pa && pb) begin
         if (key_rank == fcc_pkg::VERDICT_NONE) begin
            key_rank = rank(sort_weight(case_fold(ca)), sort_weight(case_fold(cb)));
         end
         if (raw_rank == fcc_pkg::VERDICT_NONE) begin
            raw_rank = rank({1'b0, ca}, {1'b0, cb});
         end
      end else if (pa) begin
         if (length_rank == fcc_pkg::VERDICT_NONE) begin
            length_rank = fcc_pkg::VERDICT_MORE;
         end
      end else if (pb) begin
         if (length_rank == fcc_pkg::VERDICT_NONE) begin
            length_rank = fcc_pkg::VERDICT_LESS;
         end
      end
      produced = fin;
      verdict.order = fcc_pkg::OrderEqual;
      verdict.basis = fcc_pkg::BASIS_EQUAL;
      if (fin) begin
         if (key_rank != fcc_pkg::VERDICT_NONE) begin
            verdict.order = order_of(key_rank);
            verdict.basis = fcc_pkg::BASIS_WEIGHT;
         end else if (length_rank != fcc_pkg::VERDICT_NONE) begin
            verdict.order = order_of(length_rank);
            verdict.basis = fcc_pkg::BASIS_LENGTH;
         end else if (raw_rank != fcc_pkg::VERDICT_NONE) begin
            verdict.order = order_of(raw_rank);
            verdict.basis = fcc_pkg::BASIS_RAW;
         end
         key_rank = fcc_pkg::VERDICT_NONE;
         length_rank = fcc_pkg::VERDICT_NONE;
         raw_rank = fcc_pkg::VERDICT_NONE;
         ended_a = 1'b0;
         ended_b = 1'b0;
      end
   endtask

   // Appends one expected verdict at the tail of the queue.
   task automatic queue_verdict(input fcc_pkg::result_type v);
      pending_verdicts.insert(pending_verdicts.size(), v);
   endtask

   // Offers one position on the request channel, optionally after an idle
   // burst, waits for the transfer and then records what it should produce.
   task automatic send_position(input logic [15:0] ca, input logic [15:0] cb,
                                input logic ha, input logic hb, input logic fin,
                                input bit gaps, input bit known,
                                input fcc_pkg::result_type typed);
      bit                  produced;
      fcc_pkg::result_type verdict;
      if (gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cb, ca};
      req_tuser  <= {hb, ha};
      req_tlast  <= fin;
      do begin
         @(posedge clock);
      end while (!req_tready);
      collate_position(ca, cb, ha, hb, fin, produced, verdict);
      if (produced) begin
         queue_verdict(known ? typed : verdict);
      end
   endtask

   // Draws a code unit, weighted toward the folded ranges and their edges.
   function automatic logic [15:0] pick_unit();
      logic [15:0] edges [10];
      edges = '{16'h0000, 16'hFFFF, 16'h0040, 16'h005B, 16'h0060,
                16'h007B, 16'h040F, 16'h0430, 16'h0400, 16'h0450};
      case ($urandom_range(0, 9))
         0, 1: return 16'h0041 + 16'($urandom_range(0, 25));
         2, 3: return 16'h0061 + 16'($urandom_range(0, 25));
         4: return 16'h0410 + 16'($urandom_range(0, 31));
         5: return 16'h0430 + 16'($urandom_range(0, 31));
         6: begin
            case ($urandom_range(0, 4))
               0: return fcc_pkg::CyrillicUpperIo;
               1: return fcc_pkg::CyrillicLowerIo;
               2: return fcc_pkg::CyrillicLowerIe;
               3: return 16'h0436;
               default: return 16'h0415;
            endcase
         end
         7: return 16'h0400 + 16'($urandom_range(0, 95));
         8: return 16'($urandom_range(0, 65535));
         default: return edges[$urandom_range(0, 9)];
      endcase
   endfunction

   // Flips the case of a unit so that the pair ties on weight but not raw.
   function automatic logic [15:0] flip_case(input logic [15:0] u);
      if ((u >= 16'h0041 && u <= 16'h005A) || (u >= 16'h0410 && u <= 16'h042F)) begin
         return u + 16'h0020;
      end
      if ((u >= 16'h0061 && u <= 16'h007A) || (u >= 16'h0430 && u <= 16'h044F)) begin
         return u - 16'h0020;
      end
      if (u == fcc_pkg::CyrillicUpperIo) begin
         return fcc_pkg::CyrillicLowerIo;
      end
      if (u == fcc_pkg::CyrillicLowerIo) begin
         return fcc_pkg::CyrillicUpperIo;
      end
      return u;
   endfunction

   // Stimulus: reset, the directed table, then random string pairs.
   initial begin
      int unsigned         sent;
      int unsigned         len_a;
      int unsigned         len_b;
      int unsigned         positions;
      int unsigned         flavor;
      bit                  noisy;
      bit                  gaps;
      logic [15:0]         str_a [MaxLen];
      logic [15:0]         str_b [MaxLen];
      logic                ha;
      logic                hb;
      fcc_pkg::result_type typed;

      key_rank = fcc_pkg::VERDICT_NONE;
      length_rank = fcc_pkg::VERDICT_NONE;
      raw_rank = fcc_pkg::VERDICT_NONE;
      ended_a = 1'b0;
      ended_b = 1'b0;
      sent = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PlanRows; r++) begin
         typed.order = plan[r].order;
         typed.basis = plan[r].basis;
         send_position(plan[r].char_a, plan[r].char_b, plan[r].has_a, plan[r].has_b,
                       plan[r].last, 1'b1, plan[r].known, typed);
         sent++;
      end

      // Mostly well-formed pairs: A, then B as a copy, a case-flipped copy, a
      // copy with units replaced at random or an unrelated string. A few pairs carry
      // random presence flags, which exercises presence after absence.
      while (sent < TargetItems) begin
         if (sent >= CalmFrom) begin
            calm <= 1'b1;
         end
         len_a = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
         len_b = ($urandom_range(0, 1) == 0) ? len_a : $urandom_range(0, 6);
         flavor = $urandom_range(0, 3);
         noisy = ($urandom_range(0, 7) == 0);
         gaps = ($urandom_range(0, 2) != 0) && (sent < CalmFrom);
         for (int p = 0; p < MaxLen; p++) begin
            str_a[p] = pick_unit();
            case (flavor)
               0: str_b[p] = str_a[p];
               1: str_b[p] = ($urandom_range(0, 2) == 0) ? str_a[p] : flip_case(str_a[p]);
               2: str_b[p] = ($urandom_range(0, 5) == 0) ? pick_unit() : str_a[p];
               default: str_b[p] = pick_unit();
            endcase
         end
         positions = ((len_a > len_b) ? len_a : len_b) + $urandom_range(0, 2);
         if (positions == 0) begin
            positions = 1;
         end
         for (int p = 0; p < positions; p++) begin
            ha = noisy ? 1'($urandom_range(0, 1)) : (p < len_a);
            hb = noisy ? 1'($urandom_range(0, 1)) : (p < len_b);
            // An absent unit carries junk, which must be ignored.
            send_position(ha ? str_a[p] : 16'($urandom_range(0, 65535)),
                          hb ? str_b[p] : 16'($urandom_range(0, 65535)),
                          ha, hb, (p == positions - 1), gaps, 1'b0, typed);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Receiver: random stall bursts between ready stretches, and steady
   // readiness once the calm phase begins.
   int unsigned hold_cycles = 0;

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
         hold_cycles <= $urandom_range(0, 20);
      end
   end

   // Result checker: each response transfer is matched against the oldest
   // expected verdict, field by field.
   always @(posedge clock) begin
      fcc_pkg::result_type want;
      logic signed [1:0]   seen_order;
      logic [1:0]          seen_basis;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_order = rsp_tdata[1:0];
         seen_basis = rsp_tdata[3:2];
         if (pending_verdicts.size() == 0) begin
            $error("unexpected response transfer: order %0d, basis %0d",
                   seen_order, seen_basis);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (seen_order !== want.order) begin
               $error("order: expected %0d, got %0d", want.order, seen_order);
               error_count++;
            end
            if (seen_basis !== want.basis) begin
               $error("basis: expected %0d, got %0d", want.basis, seen_basis);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QuietLimit) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

endmodule
